>>> rtl/core/pbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poisson blend solver package
// Shared request and result types, codes and default sizes.
// ----------------------------------------------------------------------------
package pbs_pkg;

  // Default geometry and fixed-point format.
  localparam int unsigned MaxWidthDef     = 64;
  localparam int unsigned MaxHeightDef    = 64;
  localparam int unsigned FractionBitsDef = 16;

  // Fixed field widths.
  localparam int unsigned PixW   = 16;
  localparam int unsigned GuideW = 19;
  localparam int unsigned CountW = 13;
  localparam int unsigned DimW   = 7;
  localparam int unsigned IterW  = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  // Opcodes; the last one is unused and ignored.
  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpSolve = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpNone  = 2'd3;

  // Result kinds.
  localparam logic [1:0] KindSolved = 2'd0;
  localparam logic [1:0] KindPixel  = 2'd1;
  localparam logic [1:0] KindBadIdx = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIter   = 2'd2;

  // Reset values.
  localparam logic [DimW-1:0]  WidthRst  = 7'd64;
  localparam logic [DimW-1:0]  HeightRst = 7'd64;
  localparam logic [IterW-1:0] IterRst   = 10'd300;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [11:0]     pixel_index;
    logic [PixW-1:0] src_red;
    logic [PixW-1:0] src_green;
    logic [PixW-1:0] src_blue;
    logic [PixW-1:0] dest_red;
    logic [PixW-1:0] dest_green;
    logic [PixW-1:0] dest_blue;
    logic            mask_bit;
  } req_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [PixW-1:0]   out_red;
    logic [PixW-1:0]   out_green;
    logic [PixW-1:0]   out_blue;
    logic [CountW-1:0] masked_count;
  } rsp_t;

endpackage

>>> rtl/core/poisson_blend_solver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poisson blend solver unit
// Gauss-Seidel Poisson blending over on-chip pixel stores, one sequencer.
// ----------------------------------------------------------------------------
// Load: the stores are written in the execute state. A bad index result is registered in the
// execute state and a read result in the read-wait state; the unit is back in idle as the
// result shows, so the next request can be taken while it is valid. Solve: with one read port
// per store, init reads each pixel and, if masked, each in-image neighbor in turn; each sweep
// does the same, then reads the guidance and divides, but leaves a lone masked pixel as is.
// After reset the unit clears all MAX_WIDTH*MAX_HEIGHT mask entries, busy high; no stalls.
module poisson_blend_solver_unit #(
  parameter int unsigned MAX_WIDTH     = pbs_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT    = pbs_pkg::MaxHeightDef,
  parameter int unsigned FRACTION_BITS = pbs_pkg::FractionBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pbs_pkg::req_t                req_i,
  output logic                         result_valid_o,
  output pbs_pkg::rsp_t                result_o,
  input  logic                         cfg_we_i,
  input  logic [pbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbs_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = pbs_pkg::PixW;
  localparam int unsigned GW    = pbs_pkg::GuideW;
  localparam int unsigned WW    = (FRACTION_BITS + 5 > PW + 1) ? FRACTION_BITS + 5 : PW + 1;
  localparam int unsigned SW    = WW + 2;
  localparam int unsigned DW    = ((SW > GW) ? SW : GW) + 1;
  localparam int unsigned Shift = DW + 1;
  localparam int unsigned PrW   = 2 * DW + 1;
  localparam int unsigned AreaW = 2 * pbs_pkg::DimW;
  localparam logic [DW-1:0] Recip3 = DW'(((65'd1 << Shift) + 65'd2) / 65'd3);
  localparam logic signed [DW-1:0] WorkMax = DW'((64'sd16 <<< FRACTION_BITS) - 64'sd1);
  localparam logic signed [DW-1:0] WorkMin = DW'(-(64'sd16 <<< FRACTION_BITS));
  localparam logic signed [WW-1:0] PixMax  = WW'((64'sd1 <<< FRACTION_BITS) - 64'sd1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EXEC, S_RDWAIT, S_INIT_RD, S_INIT_CHK, S_G_RD, S_G_ACC,
    S_W_RD, S_W_CHK, S_W_NB, S_W_ACC, S_W_GD, S_W_DIV, S_DONE
  } state_e;

  state_e        state_q;
  pbs_pkg::req_t req_q;

  // Configuration registers.
  logic [pbs_pkg::DimW-1:0]  width_q, height_q;
  logic [pbs_pkg::IterW-1:0] iter_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= pbs_pkg::WidthRst;
      height_q   <= pbs_pkg::HeightRst;
      iter_cfg_q <= pbs_pkg::IterRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbs_pkg::RegWidth:  width_q    <= cfg_data_i[pbs_pkg::DimW-1:0];
        pbs_pkg::RegHeight: height_q   <= cfg_data_i[pbs_pkg::DimW-1:0];
        pbs_pkg::RegIter:   iter_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective image size after clamping.
  logic [pbs_pkg::DimW-1:0] w_eff, h_eff;
  logic [AreaW-1:0]         area;
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = 7'd1;
    else if (32'(width_q) > MAX_WIDTH) w_eff = pbs_pkg::DimW'(MAX_WIDTH);
    h_eff = height_q;
    if (height_q == '0) h_eff = 7'd1;
    else if (32'(height_q) > MAX_HEIGHT) h_eff = pbs_pkg::DimW'(MAX_HEIGHT);
    area = AreaW'(w_eff) * AreaW'(h_eff);
  end

  // Pixel stores and their registered read data.
  logic [3*PW-1:0] src_mem [Depth];
  logic [3*PW-1:0] dst_mem [Depth];
  logic            msk_mem [Depth];
  logic [3*WW-1:0] wrk_mem [Depth];
  logic [3*GW-1:0] gd_mem  [Depth];
  logic [3*PW-1:0] src_rd_q, dst_rd_q;
  logic            msk_rd_q;
  logic [3*WW-1:0] wrk_rd_q;
  logic [3*GW-1:0] gd_rd_q;

  logic [AW-1:0]   rd_addr, wr_addr;
  logic            ld_we, msk_we, wrk_we, gd_we;
  logic            msk_wdata;
  logic [3*WW-1:0] wrk_wdata;
  logic [3*GW-1:0] gd_wdata;

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      src_mem[wr_addr] <= {req_q.src_blue, req_q.src_green, req_q.src_red};
      dst_mem[wr_addr] <= {req_q.dest_blue, req_q.dest_green, req_q.dest_red};
    end
    if (msk_we) msk_mem[wr_addr] <= msk_wdata;
    if (wrk_we) wrk_mem[wr_addr] <= wrk_wdata;
    if (gd_we)  gd_mem[wr_addr]  <= gd_wdata;
    src_rd_q <= src_mem[rd_addr];
    dst_rd_q <= dst_mem[rd_addr];
    msk_rd_q <= msk_mem[rd_addr];
    wrk_rd_q <= wrk_mem[rd_addr];
    gd_rd_q  <= gd_mem[rd_addr];
  end

  // Sequencer registers.
  logic [AW-1:0]             p_q;
  logic [pbs_pkg::DimW-1:0]  x_q, y_q;
  logic [2:0]                k_q, n_q;
  logic [pbs_pkg::IterW-1:0] it_q;
  logic [AW:0]               cnt_q;
  logic [3*PW-1:0]           src_p_q;
  logic signed [GW-1:0]      g_q   [3];
  logic signed [SW-1:0]      sum_q [3];
  logic [DW-1:0]             mag_q [3];
  logic                      neg_q [3];
  logic [PrW-1:0]            prod_q [3];

  // Neighbor selection: right, left, up, down.
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic          last_pix;
  logic          idx_bad;
  always_comb begin
    nb_ok   = 1'b0;
    nb_addr = p_q;
    case (k_q)
      3'd0: begin nb_ok = (x_q + 7'd1) < w_eff; nb_addr = p_q + AW'(1); end
      3'd1: begin nb_ok = x_q != '0;            nb_addr = p_q - AW'(1); end
      3'd2: begin nb_ok = y_q != '0;            nb_addr = p_q - AW'(w_eff); end
      3'd3: begin nb_ok = (y_q + 7'd1) < h_eff; nb_addr = p_q + AW'(w_eff); end
      default: ;
    endcase
    last_pix = (x_q == w_eff - 7'd1) && (y_q == h_eff - 7'd1);
    idx_bad  = AreaW'(req_q.pixel_index) >= area;
  end

  // Per-channel arithmetic lanes.
  logic signed [GW-1:0] g_nx   [3];
  logic signed [SW-1:0] sum_nx [3];
  logic signed [DW-1:0] diff   [3];
  logic [DW-1:0]        mag_nx [3];
  logic [DW-1:0]        quo    [3];
  logic signed [DW-1:0] res    [3];
  logic signed [DW-1:0] sat    [3];
  logic signed [WW-1:0] wv     [3];
  logic [PW-1:0]        rd_pix [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      g_nx[c] = g_q[c] + GW'(src_rd_q[c*PW +: PW]) - GW'(src_p_q[c*PW +: PW]);
      sum_nx[c] = sum_q[c] + SW'(signed'(wrk_rd_q[c*WW +: WW]));
      diff[c] = DW'(sum_q[c]) - DW'(signed'(gd_rd_q[c*GW +: GW]));
      mag_nx[c] = diff[c][DW-1] ? DW'(-diff[c]) : DW'(diff[c]);
      case (n_q)
        3'd2:    quo[c] = mag_q[c] >> 1;
        3'd3:    quo[c] = DW'(prod_q[c] >> Shift);
        3'd4:    quo[c] = mag_q[c] >> 2;
        default: quo[c] = mag_q[c];
      endcase
      res[c] = neg_q[c] ? -signed'(quo[c]) : signed'(quo[c]);
      sat[c] = res[c];
      if (res[c] > WorkMax) sat[c] = WorkMax;
      if (res[c] < WorkMin) sat[c] = WorkMin;
      // Read path: masked pixels clamp to the unit range.
      wv[c] = signed'(wrk_rd_q[c*WW +: WW]);
      if (!msk_rd_q) rd_pix[c] = dst_rd_q[c*PW +: PW];
      else if (wv[c] < 0) rd_pix[c] = '0;
      else if (wv[c] > PixMax) rd_pix[c] = PW'(PixMax);
      else rd_pix[c] = PW'(wv[c]);
    end
  end

  // Memory addressing and write strobes.
  always_comb begin
    rd_addr   = p_q;
    wr_addr   = p_q;
    ld_we     = 1'b0;
    msk_we    = 1'b0;
    msk_wdata = 1'b0;
    wrk_we    = 1'b0;
    gd_we     = 1'b0;
    wrk_wdata = '0;
    gd_wdata  = {g_q[2], g_q[1], g_q[0]};
    unique case (state_q)
      S_CLR: msk_we = 1'b1;
      S_EXEC: begin
        rd_addr = AW'(req_q.pixel_index);
        wr_addr = AW'(req_q.pixel_index);
        if (!idx_bad && req_q.opcode == pbs_pkg::OpLoad) begin
          ld_we     = 1'b1;
          msk_we    = 1'b1;
          msk_wdata = req_q.mask_bit;
        end
      end
      S_INIT_CHK: begin
        wrk_we    = 1'b1;
        wrk_wdata = {WW'(dst_rd_q[2*PW +: PW]), WW'(dst_rd_q[PW +: PW]),
                     WW'(dst_rd_q[0 +: PW])};
      end
      S_G_RD: begin
        rd_addr = nb_addr;
        gd_we   = k_q == 3'd4;
      end
      S_W_NB: rd_addr = (k_q == 3'd4) ? p_q : nb_addr;
      S_W_DIV: begin
        wrk_we    = 1'b1;
        wrk_wdata = {WW'(sat[2]), WW'(sat[1]), WW'(sat[0])};
      end
      default: ;
    endcase
  end

  assign busy = state_q != S_IDLE;

  // Sequencer and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      req_q          <= '0;
      p_q            <= '0;
      x_q            <= '0;
      y_q            <= '0;
      k_q            <= '0;
      n_q            <= '0;
      it_q           <= '0;
      src_p_q        <= '0;
      result_valid_o <= 1'b0;
      result_o       <= '0;
      cnt_q          <= '0;
      for (int c = 0; c < 3; c++) begin
        g_q[c]    <= '0;
        sum_q[c]  <= '0;
        mag_q[c]  <= '0;
        neg_q[c]  <= 1'b0;
        prod_q[c] <= '0;
      end
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          p_q <= p_q + AW'(1);
          if (32'(p_q) == Depth - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req_q   <= req_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          result_o <= '0;
          if (req_q.opcode == pbs_pkg::OpSolve) begin
            p_q     <= '0;
            x_q     <= '0;
            y_q     <= '0;
            cnt_q   <= '0;
            state_q <= S_INIT_RD;
          end else if (req_q.opcode != pbs_pkg::OpLoad && req_q.opcode != pbs_pkg::OpRead) begin
            state_q <= S_IDLE;
          end else if (idx_bad) begin
            result_o.result_kind <= pbs_pkg::KindBadIdx;
            result_valid_o       <= 1'b1;
            state_q              <= S_IDLE;
          end else if (req_q.opcode == pbs_pkg::OpLoad) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RDWAIT;
          end
        end
        S_RDWAIT: begin
          result_o.result_kind <= pbs_pkg::KindPixel;
          result_o.out_red     <= rd_pix[0];
          result_o.out_green   <= rd_pix[1];
          result_o.out_blue    <= rd_pix[2];
          result_valid_o       <= 1'b1;
          state_q              <= S_IDLE;
        end
        S_INIT_RD: state_q <= S_INIT_CHK;
        S_INIT_CHK: begin
          src_p_q <= src_rd_q;
          for (int c = 0; c < 3; c++) g_q[c] <= '0;
          k_q <= '0;
          if (msk_rd_q) begin
            cnt_q   <= cnt_q + (AW+1)'(1);
            state_q <= S_G_RD;
          end else begin
            state_q <= S_INIT_RD;
          end
          if (!msk_rd_q) begin
            if (last_pix) begin
              p_q <= '0; x_q <= '0; y_q <= '0; it_q <= '0;
              state_q <= (iter_cfg_q == '0) ? S_DONE : S_W_RD;
            end else begin
              p_q <= p_q + AW'(1);
              x_q <= (x_q == w_eff - 7'd1) ? '0 : x_q + 7'd1;
              if (x_q == w_eff - 7'd1) y_q <= y_q + 7'd1;
            end
          end
        end
        // Guidance: gather source differences to each in-image neighbor.
        S_G_RD: begin
          if (k_q == 3'd4) begin
            if (last_pix) begin
              p_q <= '0; x_q <= '0; y_q <= '0; it_q <= '0;
              state_q <= (iter_cfg_q == '0) ? S_DONE : S_W_RD;
            end else begin
              p_q <= p_q + AW'(1);
              x_q <= (x_q == w_eff - 7'd1) ? '0 : x_q + 7'd1;
              if (x_q == w_eff - 7'd1) y_q <= y_q + 7'd1;
              state_q <= S_INIT_RD;
            end
          end else if (nb_ok) begin
            state_q <= S_G_ACC;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_G_ACC: begin
          for (int c = 0; c < 3; c++) g_q[c] <= g_nx[c];
          k_q     <= k_q + 3'd1;
          state_q <= S_G_RD;
        end
        // Sweep: one in-place update per masked pixel that has an in-image neighbor.
        S_W_RD: state_q <= S_W_CHK;
        S_W_CHK: begin
          for (int c = 0; c < 3; c++) sum_q[c] <= '0;
          k_q <= '0;
          n_q <= '0;
          if (msk_rd_q) begin
            state_q <= S_W_NB;
          end else begin
            state_q <= S_W_RD;
            if (last_pix) begin
              p_q <= '0; x_q <= '0; y_q <= '0;
              it_q <= it_q + 10'd1;
              if (it_q + 10'd1 == iter_cfg_q) state_q <= S_DONE;
            end else begin
              p_q <= p_q + AW'(1);
              x_q <= (x_q == w_eff - 7'd1) ? '0 : x_q + 7'd1;
              if (x_q == w_eff - 7'd1) y_q <= y_q + 7'd1;
            end
          end
        end
        S_W_NB: begin
          if (k_q == 3'd4) begin
            if (n_q == '0) begin
              state_q <= S_W_RD;
              if (last_pix) begin
                p_q <= '0; x_q <= '0; y_q <= '0;
                it_q <= it_q + 10'd1;
                if (it_q + 10'd1 == iter_cfg_q) state_q <= S_DONE;
              end else begin
                p_q <= p_q + AW'(1);
                x_q <= (x_q == w_eff - 7'd1) ? '0 : x_q + 7'd1;
                if (x_q == w_eff - 7'd1) y_q <= y_q + 7'd1;
              end
            end else begin
              state_q <= S_W_GD;
            end
          end else if (nb_ok) begin
            state_q <= S_W_ACC;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_W_ACC: begin
          for (int c = 0; c < 3; c++) sum_q[c] <= sum_nx[c];
          n_q     <= n_q + 3'd1;
          k_q     <= k_q + 3'd1;
          state_q <= S_W_NB;
        end
        // Divide by the neighbor count: magnitude, then reciprocal for three.
        S_W_GD: begin
          for (int c = 0; c < 3; c++) begin
            mag_q[c]  <= mag_nx[c];
            neg_q[c]  <= diff[c][DW-1];
            prod_q[c] <= PrW'(mag_nx[c]) * PrW'(Recip3);
          end
          state_q <= S_W_DIV;
        end
        S_W_DIV: begin
          state_q <= S_W_RD;
          if (last_pix) begin
            p_q <= '0; x_q <= '0; y_q <= '0;
            it_q <= it_q + 10'd1;
            if (it_q + 10'd1 == iter_cfg_q) state_q <= S_DONE;
          end else begin
            p_q <= p_q + AW'(1);
            x_q <= (x_q == w_eff - 7'd1) ? '0 : x_q + 7'd1;
            if (x_q == w_eff - 7'd1) y_q <= y_q + 7'd1;
          end
        end
        S_DONE: begin
          result_o.result_kind  <= pbs_pkg::KindSolved;
          result_o.masked_count <= pbs_pkg::CountW'(cnt_q);
          result_valid_o        <= 1'b1;
          state_q               <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
